>>> rtl/etd_pkg.sv
// Package with the constants, types and commands of the elliptic transient detector.
`timescale 1ns / 1ps
package etd_pkg;

  localparam int AVG_LEN     = 32;
  localparam int AVG_LOG2    = $clog2(AVG_LEN);
  localparam int SAMPLE_BITS = 16;
  localparam int POS_W       = AVG_LOG2;
  localparam int TOTAL_W     = SAMPLE_BITS + AVG_LOG2;
  localparam int DEV_W       = SAMPLE_BITS + 1;
  localparam int MAG_W       = SAMPLE_BITS;
  localparam int SQ_W        = 2 * MAG_W;
  localparam int WEIGHT_W    = 32;
  localparam int PROD_W      = SQ_W + WEIGHT_W;
  localparam int CNT_W       = $clog2(AVG_LEN + 1);
  localparam int CFG_IDX_W   = 1;

  localparam logic [PROD_W-1:0]   TEST_LIMIT   = PROD_W'(1) << 24;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(65536);

  localparam logic [CFG_IDX_W-1:0] REG_VO_WEIGHT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IO_WEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOT,
    ST_DEV,
    ST_SQ,
    ST_MUL,
    ST_FIN
  } etd_state_t;

  typedef struct packed {
    logic capture;
    logic tot;
    logic dev;
    logic sq;
    logic mul;
    logic fin;
  } etd_cmd_t;

endpackage

>>> rtl/etd_ctrl.sv
// Controller state machine that sequences one item through the detector datapath.
`timescale 1ns / 1ps
module etd_ctrl import etd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output etd_cmd_t cmd
);

  etd_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_TOT;
        end
      end
      ST_TOT: begin
        cmd.tot   = 1'b1;
        state_nxt = ST_DEV;
      end
      ST_DEV: begin
        cmd.dev   = 1'b1;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.fin       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/etd_datapath.sv
// Datapath with the sample rings, running totals, elliptic test and flag window.
`timescale 1ns / 1ps
module etd_datapath import etd_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  etd_cmd_t                      cmd,
  input  logic signed [SAMPLE_BITS-1:0] in_vo_sample,
  input  logic signed [SAMPLE_BITS-1:0] in_io_sample,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [WEIGHT_W-1:0]           cfg_wdata,
  output logic                          out_transient,
  output logic                          out_sample_outside
);

  logic [SAMPLE_BITS-1:0] vmem [AVG_LEN];
  logic [SAMPLE_BITS-1:0] cmem [AVG_LEN];
  logic [AVG_LEN-1:0]     ring_vld_r;
  logic [AVG_LEN-1:0]     flag_ring_r;

  logic [WEIGHT_W-1:0] vo_weight_r, io_weight_r;
  logic [POS_W-1:0]    pos_r;
  logic signed [TOTAL_W-1:0] vtot_r, ctot_r;
  logic [CNT_W-1:0]    cnt_r;

  logic signed [SAMPLE_BITS-1:0] samp_v_r, samp_c_r;
  logic [SAMPLE_BITS-1:0]        vrd_r, crd_r;
  logic                          rd_vld_r, flag_old_r;
  logic [MAG_W-1:0]              mag_v_r, mag_c_r;
  logic [SQ_W-1:0]               sq_v_r, sq_c_r;
  logic [PROD_W-1:0]             prod_v_r, prod_c_r;
  logic                          big_v_r, big_c_r;
  logic                          out_transient_r, out_outside_r;

  logic signed [SAMPLE_BITS-1:0] old_v, old_c, mean_v, mean_c;
  logic signed [DEV_W-1:0]       diff_v, diff_c, dev_v, dev_c, abs_v, abs_c;
  logic [PROD_W:0]               test_sum;
  logic                          outside;
  logic [CNT_W-1:0]              cnt_dec, cnt_nxt;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      vrd_r <= vmem[pos_r];
      crd_r <= cmem[pos_r];
    end
    if (cmd.tot) begin
      vmem[pos_r] <= samp_v_r;
      cmem[pos_r] <= samp_c_r;
    end
  end

  assign old_v  = rd_vld_r ? vrd_r : '0;
  assign old_c  = rd_vld_r ? crd_r : '0;
  assign diff_v = DEV_W'(samp_v_r) - DEV_W'(old_v);
  assign diff_c = DEV_W'(samp_c_r) - DEV_W'(old_c);

  assign mean_v = SAMPLE_BITS'(vtot_r >>> AVG_LOG2);
  assign mean_c = SAMPLE_BITS'(ctot_r >>> AVG_LOG2);
  assign dev_v  = DEV_W'(samp_v_r) - DEV_W'(mean_v);
  assign dev_c  = DEV_W'(samp_c_r) - DEV_W'(mean_c);
  assign abs_v  = dev_v[DEV_W-1] ? -dev_v : dev_v;
  assign abs_c  = dev_c[DEV_W-1] ? -dev_c : dev_c;

  assign test_sum = {1'b0, prod_v_r} + {1'b0, prod_c_r};
  assign outside  = big_v_r | big_c_r | (test_sum > {1'b0, TEST_LIMIT});
  assign cnt_dec  = (flag_old_r && cnt_r != '0) ? cnt_r - CNT_W'(1) : cnt_r;
  assign cnt_nxt  = cnt_dec + CNT_W'(outside);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      samp_v_r   <= in_vo_sample;
      samp_c_r   <= in_io_sample;
      rd_vld_r   <= ring_vld_r[pos_r];
      flag_old_r <= flag_ring_r[pos_r];
    end
    if (cmd.dev) begin
      mag_v_r <= abs_v[MAG_W-1:0];
      mag_c_r <= abs_c[MAG_W-1:0];
    end
    if (cmd.sq) begin
      sq_v_r <= mag_v_r * mag_v_r;
      sq_c_r <= mag_c_r * mag_c_r;
    end
    if (cmd.mul) begin
      prod_v_r <= PROD_W'(sq_v_r) * PROD_W'(vo_weight_r);
      prod_c_r <= PROD_W'(sq_c_r) * PROD_W'(io_weight_r);
      big_v_r  <= (vo_weight_r != '0) && (PROD_W'(sq_v_r) > TEST_LIMIT);
      big_c_r  <= (io_weight_r != '0) && (PROD_W'(sq_c_r) > TEST_LIMIT);
    end
    if (cmd.fin) begin
      out_transient_r <= (cnt_nxt != '0);
      out_outside_r   <= outside;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_vld_r  <= '0;
      flag_ring_r <= '0;
      pos_r       <= '0;
      vtot_r      <= '0;
      ctot_r      <= '0;
      cnt_r       <= '0;
      vo_weight_r <= WEIGHT_RESET;
      io_weight_r <= WEIGHT_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_VO_WEIGHT: vo_weight_r <= cfg_wdata;
          REG_IO_WEIGHT: io_weight_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.tot) begin
        vtot_r            <= vtot_r + TOTAL_W'(diff_v);
        ctot_r            <= ctot_r + TOTAL_W'(diff_c);
        ring_vld_r[pos_r] <= 1'b1;
      end
      if (cmd.fin) begin
        flag_ring_r[pos_r] <= outside;
        cnt_r              <= cnt_nxt;
        pos_r              <= (pos_r == POS_W'(AVG_LEN - 1)) ? '0 : pos_r + POS_W'(1);
      end
    end
  end

  assign out_transient      = out_transient_r;
  assign out_sample_outside = out_outside_r;

endmodule

>>> rtl/elliptic_transient_detector_core.sv
// Top level of the elliptic transient detector: controller plus datapath.
// After an item is accepted it passes through totals, deviation, squaring,
// weighting, and the final test with flag window update, which presents the result.
// One item is in work at a time, so a new item is taken only after the last one
// has finished; a result waiting on out_ready holds the next final step.
// Synchronous reset clears ring valid bits, totals, flags and position; weights go to 65536.
`timescale 1ns / 1ps
module elliptic_transient_detector_core import etd_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_vo_sample,
  input  logic signed [SAMPLE_BITS-1:0] in_io_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_transient,
  output logic                          out_sample_outside,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [WEIGHT_W-1:0]           cfg_wdata
);

  etd_cmd_t cmd;

  etd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  etd_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_vo_sample       (in_vo_sample),
    .in_io_sample       (in_io_sample),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_transient      (out_transient),
    .out_sample_outside (out_sample_outside)
  );

endmodule
